FILE: design/kce_pkg.sv
package kce_pkg;

   localparam int PIXEL_W      = 8;
   localparam int WIDTH_REG_W  = 11;
   localparam int HEIGHT_REG_W = 13;
   localparam int ROW_W        = 12;
   localparam int MAX_HEIGHT   = 4096;
   localparam int MIN_DIM      = 3;
   localparam int CSR_INDEX_W  = 4;
   localparam int CSR_DATA_W   = 13;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int RING_N       = 8;
   localparam int SUM3_W       = 10;
   localparam int TOTAL_W      = 11;

   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_WIDTH  = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_HEIGHT = 4'd1;

   // eight ring neighbours, clockwise from top-left, plus end-of-frame mark
   typedef struct packed {
      logic [RING_N-1:0][PIXEL_W-1:0] ring;
      logic                           frame_last;
   } kce_item_type;

endpackage

FILE: design/kirsch_compass_edge_top.sv
// Kirsch compass edge detector, 3x3 window, streaming.
// req_*: 8-bit grey pixels in raster order, one request per pixel.
// rsp_*: one result per full window (row >= 2 and column >= 2), i.e.
//   (W-2)*(H-2) results per W x H frame; tlast marks the frame's final one.
//   The value is the largest of the eight compass responses, shifted right
//   by two and saturated at 255.
// csr_*: index 0 image width (3..MAX_WIDTH), index 1 image height (3..4096);
//   out-of-range values are clipped, other indexes are ignored.
// Throughput one pixel per clock while req_tready is high. rsp_tvalid rises
//   after the request completing its window passes the line store read register
//   (loaded as it is taken), queue, two arithmetic stages, output register.
// After reset the line stores are zeroed, one column per clock, so req_tready
//   stays low until every column is cleared; width 640 and height 480 are loaded.
// A stalled rsp_tready backs up the arithmetic stages and a four-entry queue;
//   req_tready drops once the queue cannot take the requests in flight.
module kirsch_compass_edge_top
   import kce_pkg::*;
#(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [PIXEL_W-1:0]     req_tdata,   // [7:0] pixel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [PIXEL_W-1:0]     rsp_tdata,   // [7:0] edge_value
   output logic                   rsp_tlast
);

   logic                   push, pop, q_valid;
   kce_item_type           push_item, pop_item;
   logic [QUEUE_CNT_W-1:0] q_count;

   kce_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_count    (q_count),
      .push       (push),
      .push_item  (push_item)
   );

   kce_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .q_valid   (q_valid),
      .pop_item  (pop_item),
      .q_count   (q_count)
   );

   kce_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .pop_item   (pop_item),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

FILE: design/kce_ram.sv
module kce_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/kce_front.sv
module kce_front
   import kce_pkg::*;
#(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [PIXEL_W-1:0]     req_tdata,
   input  logic [QUEUE_CNT_W-1:0] q_count,
   output logic                   push,
   output kce_item_type           push_item
);

   localparam int CW = $clog2(MAX_WIDTH);

   logic [WIDTH_REG_W-1:0]  width_ff;
   logic [HEIGHT_REG_W-1:0] height_ff;
   logic                    clear_ff;
   logic [CW-1:0]           clear_addr_ff;
   logic [CW-1:0]           col_ff, col_in;
   logic [ROW_W-1:0]        row_ff, row_in;
   logic [CW-1:0]           ew_m1, col_eff;
   logic [ROW_W-1:0]        eh_m1, row_eff;
   logic                    last_col, last_row, accept;

   logic                    s1_valid_ff;
   logic [PIXEL_W-1:0]      s1_px_ff;
   logic [CW-1:0]           s1_col_ff;
   logic                    s1_emit_ff;
   logic                    s1_last_ff;

   logic [PIXEL_W-1:0]      win_ff [9];
   logic [PIXEL_W-1:0]      win_in [9];

   logic                    ram_wr_en;
   logic [CW-1:0]           ram_wr_addr;
   logic [2*PIXEL_W-1:0]    ram_wr_data, ram_rd_data;

   assign csr_ready = 1'b1;

   // effective bounds, minus one
   always_comb begin
      if (width_ff < WIDTH_REG_W'(MIN_DIM)) begin
         ew_m1 = CW'(MIN_DIM - 1);
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         ew_m1 = CW'(MAX_WIDTH - 1);
      end else begin
         ew_m1 = CW'(width_ff - 1'b1);
      end
      if (height_ff < HEIGHT_REG_W'(MIN_DIM)) begin
         eh_m1 = ROW_W'(MIN_DIM - 1);
      end else if (32'(height_ff) > 32'(MAX_HEIGHT)) begin
         eh_m1 = ROW_W'(MAX_HEIGHT - 1);
      end else begin
         eh_m1 = ROW_W'(height_ff - 1'b1);
      end
   end

   // a counter past a shrunken bound counts as sitting on it
   assign last_col = (col_ff >= ew_m1);
   assign last_row = (row_ff >= eh_m1);
   assign col_eff  = last_col ? ew_m1 : col_ff;
   assign row_eff  = last_row ? eh_m1 : row_ff;

   always_comb begin
      if (last_col) begin
         col_in = '0;
         row_in = last_row ? '0 : row_eff + 1'b1;
      end else begin
         col_in = col_eff + 1'b1;
         row_in = row_eff;
      end
   end

   assign req_tready = !clear_ff &&
                       ((q_count + QUEUE_CNT_W'(s1_valid_ff)) < QUEUE_CNT_W'(QUEUE_DEPTH));
   assign accept     = req_tvalid && req_tready;

   // line stores share one entry per column: upper byte row above, lower two above
   assign ram_wr_en   = clear_ff || s1_valid_ff;
   assign ram_wr_addr = clear_ff ? clear_addr_ff : s1_col_ff;
   assign ram_wr_data = clear_ff ? '0 : {s1_px_ff, ram_rd_data[2*PIXEL_W-1:PIXEL_W]};

   kce_ram #(
      .WIDTH (2 * PIXEL_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (accept),
      .rd_addr (col_eff),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      win_in[0] = win_ff[1];
      win_in[1] = win_ff[2];
      win_in[2] = ram_rd_data[PIXEL_W-1:0];
      win_in[3] = win_ff[4];
      win_in[4] = win_ff[5];
      win_in[5] = ram_rd_data[2*PIXEL_W-1:PIXEL_W];
      win_in[6] = win_ff[7];
      win_in[7] = win_ff[8];
      win_in[8] = s1_px_ff;
   end

   assign push                = s1_valid_ff && s1_emit_ff;
   assign push_item.ring[0]   = win_in[0];
   assign push_item.ring[1]   = win_in[1];
   assign push_item.ring[2]   = win_in[2];
   assign push_item.ring[3]   = win_in[5];
   assign push_item.ring[4]   = win_in[8];
   assign push_item.ring[5]   = win_in[7];
   assign push_item.ring[6]   = win_in[6];
   assign push_item.ring[7]   = win_in[3];
   assign push_item.frame_last = s1_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= WIDTH_REG_W'(640);
         height_ff     <= HEIGHT_REG_W'(480);
         clear_ff      <= 1'b1;
         clear_addr_ff <= '0;
         col_ff        <= '0;
         row_ff        <= '0;
         s1_valid_ff   <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_IMAGE_WIDTH:  width_ff  <= csr_data[WIDTH_REG_W-1:0];
               REG_IMAGE_HEIGHT: height_ff <= csr_data;
               default: ;
            endcase
         end
         if (clear_ff) begin
            clear_addr_ff <= clear_addr_ff + 1'b1;
            if (clear_addr_ff == CW'(MAX_WIDTH - 1)) begin
               clear_ff <= 1'b0;
            end
         end
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_px_ff   <= req_tdata;
         s1_col_ff  <= col_eff;
         s1_emit_ff <= (row_eff >= ROW_W'(2)) && (col_eff >= CW'(2));
         s1_last_ff <= last_col && last_row;
      end
      if (s1_valid_ff) begin
         win_ff <= win_in;
      end
   end

`ifndef SYNTHESIS
   a_no_request_while_clearing: assert property (@(posedge clock) disable iff (reset)
      accept |-> !clear_ff)
      else $error("request taken during line store clear");
   a_no_port_clash: assert property (@(posedge clock) disable iff (reset)
      (accept && s1_valid_ff) |-> (col_eff != s1_col_ff))
      else $error("line store read and write hit the same column");
`endif

endmodule

FILE: design/kce_queue.sv
module kce_queue
   import kce_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  kce_item_type           push_item,
   input  logic                   pop,
   output logic                   q_valid,
   output kce_item_type           pop_item,
   output logic [QUEUE_CNT_W-1:0] q_count
);

   kce_item_type           mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0] count_ff;

   assign q_valid  = (count_ff != '0);
   assign pop_item = mem_ff[rd_ptr_ff];
   assign q_count  = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + QUEUE_CNT_W'(push) - QUEUE_CNT_W'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff < QUEUE_CNT_W'(QUEUE_DEPTH)) || pop)
      else $error("queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_valid)
      else $error("queue underflow");
`endif

endmodule

FILE: design/kce_back.sv
module kce_back
   import kce_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  kce_item_type       pop_item,
   output logic               pop,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [PIXEL_W-1:0] rsp_tdata,
   output logic               rsp_tlast
);

   logic                   v1_ff, v2_ff, out_v_ff;
   logic                   en1, en2, en3;
   logic [SUM3_W-1:0]      sum3_ff [RING_N];
   logic [SUM3_W-1:0]      sum3_in [RING_N];
   logic [TOTAL_W-1:0]     total1_ff, total2_ff, total_in;
   logic                   last1_ff, last2_ff, out_last_ff;
   logic [SUM3_W-1:0]      best_ff, best_in;
   logic [SUM3_W-1:0]      m01, m23, m45, m67, m0123, m4567;
   logic [SUM3_W+2:0]      pos_part, neg_part, diff;
   logic [SUM3_W:0]        quarter;
   logic [PIXEL_W-1:0]     edge_in, out_data_ff;

   assign en3 = !out_v_ff || rsp_tready;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign pop = q_valid && en1;

   // triples of consecutive ring neighbours
   always_comb begin
      for (int k = 0; k < RING_N; k++) begin
         sum3_in[k] = SUM3_W'(pop_item.ring[k])
                    + SUM3_W'(pop_item.ring[(k + 1) % RING_N])
                    + SUM3_W'(pop_item.ring[(k + 2) % RING_N]);
      end
      total_in = TOTAL_W'(sum3_in[0]) + TOTAL_W'(sum3_in[3])
               + TOTAL_W'(pop_item.ring[6]) + TOTAL_W'(pop_item.ring[7]);
   end

   always_comb begin
      m01     = (sum3_ff[0] > sum3_ff[1]) ? sum3_ff[0] : sum3_ff[1];
      m23     = (sum3_ff[2] > sum3_ff[3]) ? sum3_ff[2] : sum3_ff[3];
      m45     = (sum3_ff[4] > sum3_ff[5]) ? sum3_ff[4] : sum3_ff[5];
      m67     = (sum3_ff[6] > sum3_ff[7]) ? sum3_ff[6] : sum3_ff[7];
      m0123   = (m01 > m23) ? m01 : m23;
      m4567   = (m45 > m67) ? m45 : m67;
      best_in = (m0123 > m4567) ? m0123 : m4567;
   end

   // 5*s - 3*(total - s) = 8*s - 3*total, clamped at zero, quartered, saturated
   always_comb begin
      pos_part = {best_ff, 3'b000};
      neg_part = {1'b0, total2_ff, 1'b0} + (SUM3_W + 3)'(total2_ff);
      diff     = pos_part - neg_part;
      quarter  = diff[SUM3_W+2:2];
      if (pos_part < neg_part) begin
         edge_in = '0;
      end else if (quarter > (SUM3_W + 1)'(255)) begin
         edge_in = PIXEL_W'(255);
      end else begin
         edge_in = quarter[PIXEL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (en1) begin
            v1_ff <= pop;
         end
         if (en2) begin
            v2_ff <= v1_ff;
         end
         if (en3) begin
            out_v_ff <= v2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         sum3_ff   <= sum3_in;
         total1_ff <= total_in;
         last1_ff  <= pop_item.frame_last;
      end
      if (en2) begin
         best_ff   <= best_in;
         total2_ff <= total1_ff;
         last2_ff  <= last1_ff;
      end
      if (en3) begin
         out_data_ff <= edge_in;
         out_last_ff <= last2_ff;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

`ifndef SYNTHESIS
   a_result_follows_stage: assert property (@(posedge clock) disable iff (reset)
      (v2_ff && en3) |=> out_v_ff)
      else $error("result lost between back-end stages");
`endif

endmodule

FILE: test/kce_edge_checker.sv
`timescale 1ns / 100ps

module kce_edge_checker
   import kce_pkg::*;
#(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [PIXEL_W-1:0]     req_tdata,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [PIXEL_W-1:0]     rsp_tdata,
   input  logic                   rsp_tlast,
   output int                     fail_count,
   output int                     pending_count,
   output int                     edges_seen
);

   typedef struct packed {
      logic [PIXEL_W-1:0] value;
      logic               frame_end;
   } edge_result_type;

   logic [WIDTH_REG_W-1:0]  width_reg;
   logic [HEIGHT_REG_W-1:0] height_reg;
   logic [PIXEL_W-1:0]      row_above  [MAX_WIDTH];
   logic [PIXEL_W-1:0]      row_above2 [MAX_WIDTH];
   logic [PIXEL_W-1:0]      window     [9];
   int unsigned             col_pos;
   int unsigned             row_pos;
   edge_result_type         expected_edges [$];
   int                      mismatches = 0;
   int                      matched = 0;

   // strongest of the eight compass kernels: 5 on three adjacent ring cells, -3 elsewhere
   function automatic logic [PIXEL_W-1:0] compass_peak(input logic [PIXEL_W-1:0] w [9]);
      int ring [RING_N];
      int total;
      int best3;
      int sum3;
      int resp;
      ring = '{int'(w[0]), int'(w[1]), int'(w[2]), int'(w[5]),
               int'(w[8]), int'(w[7]), int'(w[6]), int'(w[3])};
      total = 0;
      best3 = 0;
      for (int k = 0; k < RING_N; k++) total += ring[k];
      for (int k = 0; k < RING_N; k++) begin
         sum3 = ring[k] + ring[(k + 1) % RING_N] + ring[(k + 2) % RING_N];
         if (sum3 > best3) best3 = sum3;
      end
      resp = 8 * best3 - 3 * total;
      if (resp < 0) resp = 0;
      resp = resp / 4;
      if (resp > 255) resp = 255;
      return resp[PIXEL_W-1:0];
   endfunction

   function automatic void advance_pixel(input logic [PIXEL_W-1:0] px);
      int unsigned        ew;
      int unsigned        eh;
      int unsigned        c;
      int unsigned        r;
      logic [PIXEL_W-1:0] up1;
      logic [PIXEL_W-1:0] up2;
      edge_result_type    res;
      ew = (width_reg < MIN_DIM) ? MIN_DIM : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
      eh = (height_reg < MIN_DIM) ? MIN_DIM :
           (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
      // counters left beyond a shrunk bound count as the last column / row
      c = (col_pos >= ew) ? ew - 1 : col_pos;
      r = (row_pos >= eh) ? eh - 1 : row_pos;
      up1 = row_above[c];
      up2 = row_above2[c];
      row_above2[c] = up1;
      row_above[c] = px;
      window[0] = window[1];
      window[1] = window[2];
      window[2] = up2;
      window[3] = window[4];
      window[4] = window[5];
      window[5] = up1;
      window[6] = window[7];
      window[7] = window[8];
      window[8] = px;
      if (r >= 2 && c >= 2) begin
         res.value = compass_peak(window);
         res.frame_end = (c == ew - 1) && (r == eh - 1);
         expected_edges.push_back(res);
      end
      if (c == ew - 1) begin
         col_pos = 0;
         row_pos = (r == eh - 1) ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
         row_pos = r;
      end
   endfunction

   always @(posedge clock) begin
      edge_result_type want;
      if (reset) begin
         width_reg = 11'd640;
         height_reg = 13'd480;
         foreach (row_above[i]) begin
            row_above[i] = '0;
            row_above2[i] = '0;
         end
         foreach (window[i]) window[i] = '0;
         col_pos = 0;
         row_pos = 0;
         expected_edges.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == REG_IMAGE_WIDTH) width_reg = csr_data[WIDTH_REG_W-1:0];
            else if (csr_index == REG_IMAGE_HEIGHT) height_reg = csr_data[HEIGHT_REG_W-1:0];
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_edges.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected result edge_value %0d frame_last %0b",
                           $realtime, rsp_tdata, rsp_tlast);
            end else begin
               want = expected_edges.pop_front();
               matched++;
               if (rsp_tdata !== want.value || rsp_tlast !== want.frame_end) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"%0t: result %0d edge_value exp %0d got %0d, ",
                               "frame_last exp %0b got %0b"},
                              $realtime, matched, want.value, rsp_tdata, want.frame_end,
                              rsp_tlast);
               end
            end
         end
         if (req_tvalid && req_tready) advance_pixel(req_tdata);
      end
      fail_count <= mismatches;
      pending_count <= expected_edges.size();
      edges_seen <= matched;
   end

endmodule

FILE: test/kirsch_compass_edge_top_tb.sv
`timescale 1ns / 100ps

module kirsch_compass_edge_top_tb;
   import kce_pkg::*;

   localparam int MAX_WIDTH       = 1024;
   localparam int RANDOM_PIXELS   = 160;
   localparam int RSP_HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES    = 8;
   localparam int WATCHDOG_LIMIT  = 4000;

   typedef enum int {TEX_NOISE, TEX_BINARY, TEX_FLAT, TEX_RAMP} texture_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [PIXEL_W-1:0]     req_tdata = '0;   // [7:0] pixel
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [PIXEL_W-1:0]     rsp_tdata;        // [7:0] edge_value
   logic                   rsp_tlast;

   int fail_count;
   int pending_count;
   int edges_seen;
   int pixels_sent = 0;
   int configs_applied = 0;
   int hold_requests = 0;
   int holds_done = 0;
   int idle_cycles = 0;
   bit sender_burst = 1'b0;
   bit receiver_burst = 1'b0;

   always #4 clock = ~clock;

   kirsch_compass_edge_top #(.MAX_WIDTH(MAX_WIDTH)) u_dut (.*);

   kce_edge_checker #(.MAX_WIDTH(MAX_WIDTH)) u_checker (.*);

   // nothing in the post-reset line clear or a long output stall comes near the limit
   always @(posedge clock) begin
      if ((csr_valid && csr_ready) || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("watchdog: no request or result moved for %0d cycles", WATCHDOG_LIMIT);
         $display("TEST FAILED");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      int gap;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (hold_requests > holds_done) begin
            rsp_tready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
            holds_done++;
         end else begin
            if ($urandom_range(0, 39) == 0) receiver_burst = !receiver_burst;
            gap = receiver_burst ? 0 : $urandom_range(0, 10);
            if (gap != 0) begin
               rsp_tready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   function automatic logic [PIXEL_W-1:0] next_pixel(input texture_type tex, input int pos,
                                                     input int base);
      int v;
      case (tex)
         TEX_BINARY: v = $urandom_range(0, 1) ? 255 : 0;
         TEX_FLAT: begin
            v = base + int'($urandom_range(0, 12)) - 6;
            if (v < 0) v = 0;
            else if (v > 255) v = 255;
         end
         TEX_RAMP: v = base + 3 * pos + int'($urandom_range(0, 3));
         default:  v = $urandom_range(0, 255);
      endcase
      return v[PIXEL_W-1:0];
   endfunction

   task automatic drain();
      req_tvalid <= 1'b0;
      // the pending count is a registered copy and trails the last request
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      // pixels that make no result may still be in the pipe
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic apply_config(input int w, input int h, input bit poke_spare);
      logic [CSR_INDEX_W-1:0] idx [3];
      logic [CSR_DATA_W-1:0]  val [3];
      int                     n;
      drain();
      idx[0] = REG_IMAGE_WIDTH;
      val[0] = CSR_DATA_W'(w);
      idx[1] = REG_IMAGE_HEIGHT;
      val[1] = CSR_DATA_W'(h);
      n = 2;
      if (poke_spare) begin
         idx[2] = CSR_INDEX_W'($urandom_range(REG_IMAGE_HEIGHT + 1, (1 << CSR_INDEX_W) - 1));
         val[2] = CSR_DATA_W'($urandom);
         n = 3;
      end
      for (int i = 0; i < n; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_data <= val[i];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
      configs_applied++;
   endtask

   task automatic send_pixel(input logic [PIXEL_W-1:0] px);
      int gap;
      if ($urandom_range(0, 39) == 0) sender_burst = !sender_burst;
      gap = sender_burst ? 0 : $urandom_range(0, 10);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= px;
      do @(posedge clock); while (!req_tready);
      pixels_sent++;
   endtask

   initial begin
      texture_type tex;
      int          w;
      int          h;
      int          len;
      int          base;
      int          random_sent;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // 3x3 frames with both sizes below the minimum, plus a write to a spare index
      apply_config(0, 1, 1'b1);
      for (int i = 0; i < 9; i++) send_pixel((i % 2) ? 8'h00 : 8'hFF);
      for (int i = 0; i < 9; i++) send_pixel((i < 3) ? 8'hFF : 8'h00);
      for (int i = 0; i < 9; i++) send_pixel(8'h80);

      // one full-width row and a little more; width first written above the
      // maximum, then rewritten to the maximum part way along the row
      apply_config((1 << WIDTH_REG_W) - 1, MIN_DIM, 1'b0);
      for (int i = 0; i < MAX_WIDTH + 8; i++) begin
         if (i == 700) apply_config(MAX_WIDTH, MIN_DIM, 1'b0);
         send_pixel(next_pixel(TEX_NOISE, i, 0));
      end

      // tallest frames, height at the maximum and beyond it; long output stall
      apply_config(4, MAX_HEIGHT, 1'b0);
      hold_requests++;
      for (int i = 0; i < 20; i++) send_pixel(next_pixel(TEX_RAMP, i, 17));
      apply_config(5, (1 << HEIGHT_REG_W) - 1, 1'b0);
      for (int i = 0; i < 20; i++) send_pixel(next_pixel(TEX_BINARY, i, 0));

      // random small frames; sizes change mid-frame with stale counters and lines
      random_sent = 0;
      while (random_sent < RANDOM_PIXELS) begin
         tex = texture_type'($urandom_range(0, 3));
         case ($urandom_range(0, 9))
            0:       w = $urandom_range(0, MIN_DIM - 1);
            1:       w = $urandom_range(0, (1 << WIDTH_REG_W) - 1);
            default: w = $urandom_range(MIN_DIM, 12);
         endcase
         case ($urandom_range(0, 9))
            0:       h = $urandom_range(0, MIN_DIM - 1);
            1, 2:    h = $urandom_range(0, (1 << HEIGHT_REG_W) - 1);
            default: h = $urandom_range(MIN_DIM, 10);
         endcase
         len = $urandom_range(10, 48);
         base = $urandom_range(0, 255);
         apply_config(w, h, $urandom_range(0, 3) == 0);
         for (int i = 0; i < len; i++) begin
            if (random_sent == RANDOM_PIXELS / 4) hold_requests++;
            send_pixel(next_pixel(tex, i, base));
            random_sent++;
         end
      end

      drain();
      $display("Streamed %0d pixels under %0d register settings; %0d edge results checked.",
               pixels_sent, configs_applied, edges_seen);
      $display("Frames from 3x3 up to a full-width row and full height, clipped sizes, resizing.");
      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

FILE: sim.f
design/kce_pkg.sv
design/kce_ram.sv
design/kce_front.sv
design/kce_queue.sv
design/kce_back.sv
design/kirsch_compass_edge_top.sv
test/kce_edge_checker.sv
test/kirsch_compass_edge_top_tb.sv
